// ----- hw/rtl/cooperative_task_scheduler_unit_assert.svh -----
// Assertion macros used by the scheduler checker.
// CTSU_ASSERT_IMP: same-cycle implication, CTSU_ASSERT_NXT: next-cycle implication.
`ifndef COOPERATIVE_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define COOPERATIVE_TASK_SCHEDULER_UNIT_ASSERT_SVH

`define CTSU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("%m: check failed");

`define CTSU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ----- hw/rtl/cts_pkg.sv -----
`default_nettype none

package cts_pkg;

	localparam int MAX_TASKS = 8;
	localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int DIV_W     = 32;
	localparam int DVS_W     = 16;
	localparam int CNT_W     = $clog2(DIV_W);

	localparam logic [DVS_W-1:0] TICK_LEN_RST = 16'd10;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_ADD  = 2'd1;
	localparam logic [1:0] MODE_DEL  = 2'd2;
	localparam logic [1:0] MODE_DISP = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_FULL = 2'd1;
	localparam logic [1:0] ERR_DEL  = 2'd2;

	typedef struct packed {
		logic [1:0]       mode;
		logic [2:0]       slot;
		logic [7:0]       task_handle;
		logic [DIV_W-1:0] delay_ms;
		logic [DIV_W-1:0] period_ms;
	} cts_req_t;

	typedef struct packed {
		logic [3:0] slot_out;
		logic [7:0] handle_out;
		logic       ran;
		logic       status;
		logic [1:0] error_code;
		logic       last;
	} cts_rsp_t;

	typedef enum logic [2:0] {
		RES_PLAIN,
		RES_ADD_OK,
		RES_ADD_FULL,
		RES_DEL,
		RES_DISP
	} res_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_ADD,
		ST_DIV,
		ST_ADD_WR,
		ST_DEL,
		ST_DISP,
		ST_ONE
	} state_t;

	typedef struct packed {
		logic      load;
		logic      tick_step;
		logic      adv;
		logic      div_start;
		logic      emit;
		res_kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic space;
		logic any_pend;
		logic full;
		logic div_busy;
		logic idx_last;
		logic cur_pend;
		logic higher_pend;
	} sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cts_div.sv -----
`default_nettype none

// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
module cts_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [cts_pkg::DIV_W-1:0] num_a,
	input  wire logic [cts_pkg::DIV_W-1:0] num_b,
	input  wire logic [cts_pkg::DVS_W-1:0] dvs,
	output logic                          busy,
	output logic [cts_pkg::DIV_W-1:0]     quo_a,
	output logic [cts_pkg::DIV_W-1:0]     quo_b
);
	import cts_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] qa_q, qb_q;
	logic [DVS_W-1:0] ra_q, rb_q, dvs_q;
	logic [DVS_W:0]   sha, shb, dfa, dfb;
	logic             gea, geb;

	always_comb begin
		sha = {ra_q, qa_q[DIV_W-1]};
		shb = {rb_q, qb_q[DIV_W-1]};
		gea = sha >= {1'b0, dvs_q};
		geb = shb >= {1'b0, dvs_q};
		dfa = sha - {1'b0, dvs_q};
		dfb = shb - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIV_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qa_q  <= num_a;
			qb_q  <= num_b;
			ra_q  <= '0;
			rb_q  <= '0;
			dvs_q <= dvs;
		end else if (busy_q) begin
			ra_q <= gea ? dfa[DVS_W-1:0] : sha[DVS_W-1:0];
			rb_q <= geb ? dfb[DVS_W-1:0] : shb[DVS_W-1:0];
			qa_q <= {qa_q[DIV_W-2:0], gea};
			qb_q <= {qb_q[DIV_W-2:0], geb};
		end
	end

	assign busy  = busy_q;
	assign quo_a = qa_q;
	assign quo_b = qb_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cts_ctrl.sv -----
`default_nettype none

// Scheduler sequencer: picks the operation, walks slots, paces results.
module cts_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic [1:0]    req_mode,
	output logic               req_ready,
	input  wire cts_pkg::sts_t sts,
	output cts_pkg::cmd_t      cmd
);
	import cts_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (req_mode)
						MODE_TICK: state_d = ST_TICK;
						MODE_ADD:  state_d = ST_ADD;
						MODE_DEL:  state_d = ST_DEL;
						MODE_DISP: state_d = sts.any_pend ? ST_DISP : ST_ONE;
					endcase
				end
			end
			ST_TICK: begin
				if (sts.idx_last)
					state_d = ST_ONE;
			end
			ST_ADD: begin
				if (!sts.full)
					state_d = ST_DIV;
				else if (sts.space)
					state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (!sts.div_busy)
					state_d = ST_ADD_WR;
			end
			ST_ADD_WR, ST_DEL, ST_ONE: begin
				if (sts.space)
					state_d = ST_IDLE;
			end
			ST_DISP: begin
				if (sts.cur_pend && sts.space && !sts.higher_pend)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		cmd.kind  = RES_PLAIN;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_TICK: begin
				cmd.tick_step = 1'b1;
				cmd.adv       = 1'b1;
			end
			ST_ADD: begin
				if (sts.full) begin
					cmd.emit = sts.space;
					cmd.kind = RES_ADD_FULL;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			ST_DIV: begin
			end
			ST_ADD_WR: begin
				cmd.emit = sts.space;
				cmd.kind = RES_ADD_OK;
			end
			ST_DEL: begin
				cmd.emit = sts.space;
				cmd.kind = RES_DEL;
			end
			ST_ONE: begin
				cmd.emit = sts.space;
			end
			ST_DISP: begin
				cmd.kind = RES_DISP;
				if (!sts.cur_pend) begin
					cmd.adv = 1'b1;
				end else if (sts.space) begin
					cmd.emit = 1'b1;
					cmd.adv  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cts_dp.sv -----
`default_nettype none

// Scheduler datapath: slot tables, tick length, divider, result register.
module cts_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cts_pkg::cts_req_t req,
	input  wire logic              wr_en,
	input  wire logic [15:0]       wr_data,
	input  wire cts_pkg::cmd_t     cmd,
	output cts_pkg::sts_t          sts,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output cts_pkg::cts_rsp_t      rsp
);
	import cts_pkg::*;

	logic [DVS_W-1:0] tick_len_q;
	cts_req_t         req_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       handle_q [MAX_TASKS];
	logic [DIV_W-1:0] delay_q  [MAX_TASKS];
	logic [DIV_W-1:0] period_q [MAX_TASKS];
	logic [7:0]       pend_q   [MAX_TASKS];
	logic [1:0]       sticky_q;
	logic             out_valid_q;
	cts_rsp_t         out_q;

	logic [MAX_TASKS-1:0] occ, pnz;
	logic [IDX_W-1:0]     free_idx, del_idx;
	logic                 del_in, del_bad, higher, space;
	logic [1:0]           sticky_d;
	logic [DVS_W-1:0]     dvs;
	logic                 div_busy;
	logic [DIV_W-1:0]     quo_a, quo_b;
	cts_rsp_t             res;

	assign dvs = (tick_len_q == '0) ? DVS_W'(1) : tick_len_q;

	cts_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num_a (req_q.delay_ms),
		.num_b (req_q.period_ms),
		.dvs   (dvs),
		.busy  (div_busy),
		.quo_a (quo_a),
		.quo_b (quo_b)
	);

	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			occ[i] = handle_q[i] != 8'd0;
			pnz[i] = pend_q[i] != 8'd0;
		end
		free_idx = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--)
			if (!occ[i])
				free_idx = IDX_W'(i);
		higher = 1'b0;
		for (int i = 0; i < MAX_TASKS; i++)
			if (i > int'(idx_q) && pnz[i])
				higher = 1'b1;
		del_idx = IDX_W'(req_q.slot);
		del_in  = int'(req_q.slot) < MAX_TASKS;
		del_bad = !del_in || !occ[del_idx];
		space   = !out_valid_q || rsp_ready;
	end

	// Sticky error as it stands after the operation being reported.
	always_comb begin
		sticky_d = sticky_q;
		if (cmd.emit) begin
			if (cmd.kind == RES_ADD_FULL)
				sticky_d = ERR_FULL;
			else if (cmd.kind == RES_DEL && del_bad)
				sticky_d = ERR_DEL;
		end
	end

	always_comb begin
		res            = '0;
		res.error_code = sticky_d;
		res.last       = 1'b1;
		unique case (cmd.kind)
			RES_PLAIN: begin
			end
			RES_ADD_OK: res.slot_out = 4'(free_idx);
			RES_ADD_FULL: begin
				res.slot_out = 4'(MAX_TASKS);
				res.status   = 1'b1;
			end
			RES_DEL: begin
				res.slot_out = {1'b0, req_q.slot};
				res.status   = del_bad;
			end
			RES_DISP: begin
				res.slot_out   = 4'(idx_q);
				res.handle_out = handle_q[idx_q];
				res.ran        = 1'b1;
				res.last       = !higher;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_len_q <= TICK_LEN_RST;
		end else if (wr_en) begin
			tick_len_q <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= req;
		if (cmd.emit)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			sticky_q    <= ERR_NONE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				handle_q[i] <= '0;
				delay_q[i]  <= '0;
				period_q[i] <= '0;
				pend_q[i]   <= '0;
			end
		end else begin
			if (cmd.load)
				idx_q <= '0;
			else if (cmd.adv)
				idx_q <= (idx_q == IDX_W'(MAX_TASKS - 1)) ? '0 : idx_q + 1'b1;

			sticky_q <= sticky_d;

			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;

			if (cmd.tick_step && occ[idx_q]) begin
				if (delay_q[idx_q] == '0) begin
					if (pend_q[idx_q] != 8'hFF)
						pend_q[idx_q] <= pend_q[idx_q] + 8'd1;
					if (period_q[idx_q] != '0)
						delay_q[idx_q] <= period_q[idx_q];
				end else begin
					delay_q[idx_q] <= delay_q[idx_q] - 1'b1;
				end
			end

			if (cmd.emit) begin
				unique case (cmd.kind)
					RES_ADD_OK: begin
						handle_q[free_idx] <= req_q.task_handle;
						delay_q[free_idx]  <= quo_a;
						period_q[free_idx] <= quo_b;
						pend_q[free_idx]   <= '0;
					end
					RES_DEL: begin
						if (del_in) begin
							handle_q[del_idx] <= '0;
							delay_q[del_idx]  <= '0;
							period_q[del_idx] <= '0;
							pend_q[del_idx]   <= '0;
						end
					end
					RES_DISP: begin
						// Drop one run; one-shot tasks leave the table.
						if (period_q[idx_q] == '0) begin
							handle_q[idx_q] <= '0;
							delay_q[idx_q]  <= '0;
							pend_q[idx_q]   <= '0;
						end else begin
							pend_q[idx_q] <= pend_q[idx_q] - 8'd1;
						end
					end
					RES_PLAIN, RES_ADD_FULL: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		sts.space       = space;
		sts.any_pend    = |pnz;
		sts.full        = &occ;
		sts.div_busy    = div_busy;
		sts.idx_last    = idx_q == IDX_W'(MAX_TASKS - 1);
		sts.cur_pend    = pnz[idx_q];
		sts.higher_pend = higher;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cooperative_task_scheduler_unit.sv -----
// Tick walks all 8 slots; add waits on the bit-serial divider unless the table is full;
// dispatch walks the slots and can wait on an output stall; one request in work.
// Walks go one slot per cycle; dispatch holds on a pending slot until output has room.
// The next request is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous): all slots free, sticky error none, tick length 10 ms.
`default_nettype none

module cooperative_task_scheduler_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Request channel
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire cts_pkg::cts_req_t req,
	// Result channel
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output cts_pkg::cts_rsp_t      rsp,
	// Tick length register, milliseconds per tick
	input  wire logic              wr_en,
	input  wire logic [15:0]       wr_data
);
	import cts_pkg::*;

	// Command from the sequencer, status back from the datapath.
	cmd_t cmd;
	sts_t sts;

	// Sequencer: accept a request in idle, then walk slots or wait on the
	// divider, and hold each result until the output register has room.
	cts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_mode (req.mode),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: slot tables, the request capture, the shared two-lane divider
	// for add, the sticky error and the single result register.
	cts_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.wr_en    (wr_en),
		.wr_data  (wr_data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/cts_chk.sv -----
`default_nettype none

`include "cooperative_task_scheduler_unit_assert.svh"

// Port-level checker for the scheduler.
module cts_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire cts_pkg::cts_req_t req,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire cts_pkg::cts_rsp_t rsp
);
	import cts_pkg::*;

	logic [1:0] outst_q;
	logic       err_seen_q;
	logic       req_acc, done_acc;

	assign req_acc  = req_valid && req_ready;
	assign done_acc = rsp_valid && rsp_ready && rsp.last;

	// Count requests taken but not yet finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q    <= '0;
			err_seen_q <= 1'b0;
		end else begin
			outst_q <= outst_q + {1'b0, req_acc} - {1'b0, done_acc};
			if (rsp_valid && rsp_ready && rsp.error_code != ERR_NONE)
				err_seen_q <= 1'b1;
		end
	end

	`CTSU_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`CTSU_ASSERT_IMP(a_rsp_owed, clk, arst_n, rsp_valid, outst_q != 2'd0)
	`CTSU_ASSERT_IMP(a_err_sticky, clk, arst_n, rsp_valid && err_seen_q, rsp.error_code != ERR_NONE)
	`CTSU_ASSERT_IMP(a_ran_ok, clk, arst_n, rsp_valid && rsp.ran, !rsp.status && rsp.handle_out != 8'd0)

endmodule

bind cooperative_task_scheduler_unit cts_chk u_cts_chk (.*);

`default_nettype wire
